// ===== hw/rtl/dbam_pkg.sv =====
// dbam_pkg: shared types and constants for the DNA bitap approximate matcher.
// Used by dbam_vectors, dna_bitap_approx_matcher and dbam_checker.
// No dependencies.
package dbam_pkg;

	localparam int DEF_MAX_EDIT_LEVELS = 12;
	localparam int DEF_MAX_PATTERN     = 32;

	localparam int BASE_W     = 2;
	localparam int DIST_W     = 4;
	localparam int PLEN_W     = 6;
	localparam int EDITS_W    = 4;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN,
		REG_PATTERN_LENGTH,
		REG_MAX_EDITS
	} cfg_reg_t;

	// One step of the vector update: enable, restart flag and text base.
	typedef struct packed {
		logic              en;
		logic              first;
		logic [BASE_W-1:0] base;
	} step_t;

endpackage

// ===== hw/rtl/dbam_vectors.sv =====
// dbam_vectors: status vector registers and the combinational Wu-Manber update.
// Produces hit/least edit level from the updated vectors.
// Depends on dbam_pkg.
module dbam_vectors #(
	parameter int LEVELS = dbam_pkg::DEF_MAX_EDIT_LEVELS,
	parameter int PAT_W  = dbam_pkg::DEF_MAX_PATTERN
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dbam_pkg::step_t               step,
	input  logic [dbam_pkg::CFG_DATA_W-1:0] pattern,
	input  logic [dbam_pkg::PLEN_W-1:0]   plen,
	input  logic [dbam_pkg::EDITS_W-1:0]  max_edits,
	output logic                          hit,
	output logic [dbam_pkg::DIST_W-1:0]   distance
);

	logic [PAT_W-1:0] sv_q [LEVELS];
	logic [PAT_W-1:0] prev [LEVELS];
	logic [PAT_W-1:0] nxt  [LEVELS];
	logic [PAT_W-1:0] mask;
	logic [PAT_W-1:0] top;
	logic [PAT_W-1:0] mism;
	logic [LEVELS-1:0] lvl_hit;
	logic [dbam_pkg::PLEN_W-1:0] m_eff;
	logic [dbam_pkg::PLEN_W-1:0] k_eff;

	// Effective length and edit limit, clamped to the built sizes
	always_comb begin
		if (plen == '0)
			m_eff = dbam_pkg::PLEN_W'(1);
		else if (plen > dbam_pkg::PLEN_W'(PAT_W))
			m_eff = dbam_pkg::PLEN_W'(PAT_W);
		else
			m_eff = plen;

		if (dbam_pkg::PLEN_W'(max_edits) > dbam_pkg::PLEN_W'(LEVELS - 1))
			k_eff = dbam_pkg::PLEN_W'(LEVELS - 1);
		else
			k_eff = dbam_pkg::PLEN_W'(max_edits);
	end

	// Bit j follows pattern base j counted from the last base
	always_comb begin
		for (int j = 0; j < PAT_W; j++) begin
			mask[j] = dbam_pkg::PLEN_W'(j) < m_eff;
			top[j]  = dbam_pkg::PLEN_W'(j) == (m_eff - dbam_pkg::PLEN_W'(1));
			mism[j] = pattern[2*j +: dbam_pkg::BASE_W] != step.base;
		end
	end

	// Level 0 takes the match term; higher levels add substitution, deletion and insertion terms
	always_comb begin
		for (int d = 0; d < LEVELS; d++)
			prev[d] = (step.first ? '1 : sv_q[d]) & mask;
		nxt[0] = ((prev[0] << 1) | mism) & mask;
		for (int d = 1; d < LEVELS; d++)
			nxt[d] = ((prev[d] << 1) | mism) & (prev[d-1] << 1) & (nxt[d-1] << 1)
				& prev[d-1] & mask;
	end

	always_comb begin
		for (int d = 0; d < LEVELS; d++)
			lvl_hit[d] = ((nxt[d] & top) == '0) && (dbam_pkg::PLEN_W'(d) <= k_eff);
		hit      = 1'b0;
		distance = '0;
		for (int d = LEVELS - 1; d >= 0; d--) begin
			if (lvl_hit[d]) begin
				hit      = 1'b1;
				distance = dbam_pkg::DIST_W'(d);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < LEVELS; d++)
				sv_q[d] <= '1;
		end else if (step.en) begin
			for (int d = 0; d < LEVELS; d++)
				sv_q[d] <= nxt[d];
		end
	end

endmodule

// ===== hw/rtl/dna_bitap_approx_matcher.sv =====
// dna_bitap_approx_matcher: top level of the DNA bitap approximate matcher.
// Holds configuration, the input stage and the result register.
// Depends on dbam_pkg and dbam_vectors.
//
// Usage:
//   Text bases enter on the in_valid/in_ready channel (base, first); each
//   base yields exactly one result on out_valid/out_ready (hit, distance).
//   Set first on the opening base of a new text to restart all edit levels.
//   Configuration (pattern, pattern_length, max_edits) is written through
//   cfg_we/cfg_index/cfg_data, one register per cycle; the user must write
//   it only while no base is in flight, which the block does not enforce;
//   index 3 is ignored. A transferred base passes the input stage, then
//   the update and the result register. Throughput: one base per cycle
//   while the receiver takes results; the status vectors update through a
//   chain of one AND stage per edit level, which sets the cycle time.
//   Reset clears both stages, loads pattern 0, length 1, max_edits 0 and sets
//   every status vector to all ones.
//   When the receiver stalls, the result register holds and the input stage
//   still takes one more base; in_ready drops only when both are full.
module dna_bitap_approx_matcher #(
	parameter int MAX_EDIT_LEVELS = dbam_pkg::DEF_MAX_EDIT_LEVELS,
	parameter int MAX_PATTERN     = dbam_pkg::DEF_MAX_PATTERN
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [dbam_pkg::BASE_W-1:0]     base,
	input  logic                            first,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            hit,
	output logic [dbam_pkg::DIST_W-1:0]     distance,
	input  logic                            cfg_we,
	input  logic [dbam_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dbam_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic [dbam_pkg::CFG_DATA_W-1:0] pattern_q;
	logic [dbam_pkg::PLEN_W-1:0]     plen_q;
	logic [dbam_pkg::EDITS_W-1:0]    edits_q;

	logic                        valid_s1;
	logic [dbam_pkg::BASE_W-1:0] base_s1;
	logic                        first_s1;

	logic                        out_valid_q;
	logic                        hit_q;
	logic [dbam_pkg::DIST_W-1:0] distance_q;

	logic                        advance;
	logic                        hit_c;
	logic [dbam_pkg::DIST_W-1:0] distance_c;
	dbam_pkg::step_t             step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			plen_q    <= dbam_pkg::PLEN_W'(1);
			edits_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				dbam_pkg::REG_PATTERN:        pattern_q <= cfg_data;
				dbam_pkg::REG_PATTERN_LENGTH: plen_q    <= cfg_data[dbam_pkg::PLEN_W-1:0];
				dbam_pkg::REG_MAX_EDITS:      edits_q   <= cfg_data[dbam_pkg::EDITS_W-1:0];
				default: ;
			endcase
		end
	end

	// Input stage moves into the result register whenever that slot frees up
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			base_s1  <= base;
			first_s1 <= first;
		end
	end

	assign step.en    = advance;
	assign step.first = first_s1;
	assign step.base  = base_s1;

	dbam_vectors #(
		.LEVELS (MAX_EDIT_LEVELS),
		.PAT_W  (MAX_PATTERN)
	) u_vectors (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.pattern   (pattern_q),
		.plen      (plen_q),
		.max_edits (edits_q),
		.hit       (hit_c),
		.distance  (distance_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			hit_q      <= hit_c;
			distance_q <= distance_c;
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = hit_q;
	assign distance  = distance_q;

endmodule

// ===== hw/rtl/dbam_checker.sv =====
// dbam_checker: port-level assertions for dna_bitap_approx_matcher.
// Bound to the top level at the end of this file.
// Depends on dbam_pkg.
module dbam_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          hit,
	input logic [dbam_pkg::DIST_W-1:0]   distance
);

	// A result without a hit always reports level zero
	a_nohit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> distance == '0)
		else $error("distance nonzero without hit");

	// A stalled result holds its fields
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(distance))
		else $error("result changed while stalled");

	// With the result register empty, input must be open
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

	// A result appearing on an empty output came from an earlier input transfer
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without matching input transfer");

endmodule

bind dna_bitap_approx_matcher dbam_checker u_dbam_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.hit       (hit),
	.distance  (distance)
);

// ===== tb/sv/tb.sv =====
// tb: self-checking testbench for dna_bitap_approx_matcher.
// Holds an edit-level bitap predictor, stimulus tasks and a result checker.
// Depends on dbam_pkg and the RTL of the matcher.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_LEVELS = dbam_pkg::DEF_MAX_EDIT_LEVELS;
	localparam int MAX_PAT    = dbam_pkg::DEF_MAX_PATTERN;
	// index past the last register; writes to it must be dropped
	localparam logic [dbam_pkg::CFG_IDX_W-1:0] REG_NONE = 2'd3;

	typedef struct packed {
		logic                        hit;
		logic [dbam_pkg::DIST_W-1:0] distance;
	} match_report_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            in_valid = 1'b0;
	logic                            in_ready;
	logic [dbam_pkg::BASE_W-1:0]     base = '0;
	logic                            first = 1'b0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	logic                            hit;
	logic [dbam_pkg::DIST_W-1:0]     distance;
	logic                            cfg_we = 1'b0;
	logic [dbam_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [dbam_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// predictor copy of registers and edit-level vectors
	logic [63:0]                  pattern_r = '0;
	logic [dbam_pkg::PLEN_W-1:0]  length_r = 6'd1;
	logic [dbam_pkg::EDITS_W-1:0] edits_r = '0;
	logic [31:0]                  status_vec [MAX_LEVELS];

	match_report_t match_reports [$];

	int gap_pct = 0;
	int stall_pct = 0;
	int edit_pct = 5;
	int unsigned hold_request = 0;
	int bases_sent = 0;
	int hits_seen = 0;
	int settings_used = 0;
	int fail_count = 0;

	dna_bitap_approx_matcher u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.base      (base),
		.first     (first),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.hit       (hit),
		.distance  (distance),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic int active_length();
		if (length_r == 0)
			return 1;
		if (length_r > MAX_PAT)
			return MAX_PAT;
		return int'(length_r);
	endfunction

	// Advance all edit levels by one text base and report the least matching level.
	function automatic match_report_t bitap_update(input logic [1:0] b, input logic f);
		logic [31:0] prev [MAX_LEVELS];
		logic [31:0] mask, top, mism;
		int m, k;
		match_report_t r;
		m = active_length();
		k = (edits_r > MAX_LEVELS - 1) ? MAX_LEVELS - 1 : int'(edits_r);
		mask = 32'hFFFF_FFFF >> (32 - m);
		top = 32'd1 << (m - 1);
		if (f)
			foreach (status_vec[d])
				status_vec[d] = '1;
		mism = '0;
		for (int j = 0; j < m; j++)
			if (pattern_r[2*j +: 2] != b)
				mism[j] = 1'b1;
		foreach (prev[d])
			prev[d] = status_vec[d] & mask;
		status_vec[0] = ((prev[0] << 1) | mism) & mask;
		for (int d = 1; d < MAX_LEVELS; d++)
			status_vec[d] = ((prev[d] << 1) | mism) & (prev[d-1] << 1)
				& (status_vec[d-1] << 1) & prev[d-1] & mask;
		r = '0;
		for (int d = k; d >= 0; d--)
			if ((status_vec[d] & top) == 0) begin
				r.hit = 1'b1;
				r.distance = d[dbam_pkg::DIST_W-1:0];
			end
		return r;
	endfunction

	// receiver: random stalls, plus a long hold counted here on request
	always @(posedge clk) begin : receiver
		int unsigned hold_left;
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// inputs only change at posedge, so negedge sees what the next edge transfers
	always @(negedge clk) begin : check_results
		match_report_t want;
		if (arst_n && out_valid && out_ready) begin
			if (match_reports.size() == 0) begin
				$error("result transfer with no base pending: hit %0d distance %0d",
					hit, distance);
				fail_count++;
			end else begin
				want = match_reports.pop_front();
				if (want.hit)
					hits_seen++;
				if (hit !== want.hit) begin
					$error("hit mismatch: expected %0d, got %0d", want.hit, hit);
					fail_count++;
				end
				if (distance !== want.distance) begin
					$error("distance mismatch: expected %0d, got %0d",
						want.distance, distance);
					fail_count++;
				end
			end
		end
	end

	task automatic send_base(input logic [1:0] b, input logic f);
		logic taken;
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		base <= b;
		first <= f;
		do begin
			@(negedge clk);
			taken = in_ready;
			@(posedge clk);
		end while (!taken);
		match_reports.push_back(bitap_update(b, f));
		bases_sent++;
	endtask

	task automatic wait_all_reported();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (match_reports.size() != 0);
	endtask

	task automatic write_reg(input logic [dbam_pkg::CFG_IDX_W-1:0] idx,
		input logic [63:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			dbam_pkg::REG_PATTERN:        pattern_r = data;
			dbam_pkg::REG_PATTERN_LENGTH: length_r = data[dbam_pkg::PLEN_W-1:0];
			dbam_pkg::REG_MAX_EDITS:      edits_r = data[dbam_pkg::EDITS_W-1:0];
			default: ;
		endcase
	endtask

	// Random settings; mostly short patterns, sometimes the extremes.
	// Vectors are kept, so the next text may continue under the new values.
	task automatic pick_config();
		logic [63:0] data;
		int sel, len;
		sel = $urandom_range(99);
		if (sel < 70)
			len = $urandom_range(1, 10);
		else if (sel < 85)
			len = $urandom_range(11, 31);
		else if (sel < 93)
			len = MAX_PAT;
		else if (sel < 97)
			len = $urandom_range(33, 63);
		else
			len = 0;
		write_reg(dbam_pkg::REG_PATTERN, {$urandom, $urandom});
		data = {$urandom, $urandom};
		data[dbam_pkg::PLEN_W-1:0] = len[dbam_pkg::PLEN_W-1:0];
		write_reg(dbam_pkg::REG_PATTERN_LENGTH, data);
		data = {$urandom, $urandom};
		write_reg(dbam_pkg::REG_MAX_EDITS, data);
		if ($urandom_range(4) == 0)
			write_reg(REG_NONE, {$urandom, $urandom});
		edit_pct = $urandom_range(0, 8);
		settings_used++;
	endtask

	// One stretch of text: usually a copy of the pattern with random edits
	// behind a short random lead, otherwise plain random bases.
	task automatic send_segment();
		int j, p;
		logic f;
		logic [1:0] code;
		f = ($urandom_range(3) == 0);
		if ($urandom_range(99) < 15) begin
			repeat ($urandom_range(1, 20)) begin
				send_base(2'($urandom_range(3)), f);
				f = 1'b0;
			end
		end else begin
			repeat ($urandom_range(5)) begin
				send_base(2'($urandom_range(3)), f);
				f = 1'b0;
			end
			j = active_length() - 1;
			while (j >= 0) begin
				code = pattern_r[2*j +: 2];
				p = $urandom_range(99);
				if (p < edit_pct) begin
					j--;   // base dropped from the text
				end else if (p < 2*edit_pct) begin
					send_base(2'($urandom_range(3)), f);
					f = 1'b0;
				end else if (p < 3*edit_pct) begin
					send_base(code ^ 2'($urandom_range(1, 3)), f);
					f = 1'b0;
					j--;
				end else begin
					send_base(code, f);
					f = 1'b0;
					j--;
				end
			end
		end
	endtask

	// reset values: pattern of A, length 1, exact match only
	task automatic test_defaults();
		send_base(2'd0, 1'b1);
		send_base(2'd1, 1'b0);
		send_base(2'd2, 1'b0);
		send_base(2'd3, 1'b0);
	endtask

	// oversized length and edit count, dropped index, then zero length
	task automatic test_saturation();
		wait_all_reported();
		write_reg(dbam_pkg::REG_PATTERN, '1);
		write_reg(dbam_pkg::REG_PATTERN_LENGTH, 64'd63);
		write_reg(dbam_pkg::REG_MAX_EDITS, 64'd15);
		write_reg(REG_NONE, 64'd5);
		settings_used++;
		send_base(2'd3, 1'b1);
		repeat (7)
			send_base(2'd3, 1'b0);
		wait_all_reported();
		write_reg(dbam_pkg::REG_PATTERN_LENGTH, 64'd0);
		settings_used++;
		send_base(2'd3, 1'b0);
		send_base(2'd0, 1'b0);
		send_base(2'd3, 1'b1);
	endtask

	// ACGTA with two edits allowed: exact copy, then one with G dropped
	task automatic test_known_motif();
		wait_all_reported();
		write_reg(dbam_pkg::REG_PATTERN, 64'b00_10_01_11_00);
		write_reg(dbam_pkg::REG_PATTERN_LENGTH, 64'd5);
		write_reg(dbam_pkg::REG_MAX_EDITS, 64'd2);
		settings_used++;
		send_base(2'd0, 1'b1);
		send_base(2'd2, 1'b0);
		send_base(2'd1, 1'b0);
		send_base(2'd3, 1'b0);
		send_base(2'd0, 1'b0);
		send_base(2'd0, 1'b1);
		send_base(2'd2, 1'b0);
		send_base(2'd3, 1'b0);
		send_base(2'd0, 1'b0);
	endtask

	task automatic test_random_traffic();
		int gaps [4] = '{0, 57, 0, 20};
		int stalls [4] = '{0, 0, 57, 20};
		int stop_at;
		for (int ph = 0; ph < 4; ph++) begin
			gap_pct = gaps[ph];
			stall_pct = stalls[ph];
			for (int s = 0; s < 3; s++) begin
				wait_all_reported();
				pick_config();
				stop_at = bases_sent + 100;
				while (bases_sent < stop_at)
					send_segment();
			end
		end
	endtask

	// long receiver hold while bases keep coming, then a full drain and more traffic
	task automatic test_backpressure();
		int stop_at;
		wait_all_reported();
		pick_config();
		gap_pct = 0;
		stall_pct = 0;
		hold_request = 150;
		stop_at = bases_sent + 40;
		while (bases_sent < stop_at)
			send_segment();
		wait_all_reported();
		stall_pct = 30;
		stop_at = bases_sent + 30;
		while (bases_sent < stop_at)
			send_segment();
	endtask

	initial begin
		foreach (status_vec[d])
			status_vec[d] = '1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_defaults();
		test_saturation();
		test_known_motif();
		test_random_traffic();
		test_backpressure();
		wait_all_reported();
		repeat (8) @(posedge clk);
		$display("Sent %0d text bases under %0d register settings; %0d hits reported.",
			bases_sent, settings_used, hits_seen);
		$display("Phases: free flow, sender gaps, receiver stalls, both, long hold.");
		if (fail_count == 0 && match_reports.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ===== dna_bitap_approx_matcher.f =====
hw/rtl/dbam_pkg.sv
hw/rtl/dbam_vectors.sv
hw/rtl/dna_bitap_approx_matcher.sv
hw/rtl/dbam_checker.sv
tb/sv/tb.sv
